/* rtl/quoted_csv_row_tokenizer_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the CSV row tokenizer
// Shared property forms used by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef QUOTED_CSV_ROW_TOKENIZER_TOP_DEFINES_SVH
`define QUOTED_CSV_ROW_TOKENIZER_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define CSVTOK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CSVTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/csvtok_pkg.sv */
// ----------------------------------------------------------------------------
// CSV row tokenizer package
// Shared constants, result codes and the result batch type.
// ----------------------------------------------------------------------------
package csvtok_pkg;

    localparam logic [7:0] MARK0           = 8'hEF;
    localparam logic [7:0] MARK1           = 8'hBB;
    localparam logic [7:0] MARK2           = 8'hBF;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_LF         = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE      = 8'h22;
    localparam logic [7:0] SEPARATOR_RESET = 8'h2C;

    localparam int MaxResults = 3;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_CELL_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END  = 2'd2;

    localparam logic [1:0] MARK_DONE = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]               count;
        result_t [MaxResults-1:0] entry;
    } batch_t;

endpackage

/* rtl/csvtok_in_if.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer source channel
// Carries one source byte or an end-of-input mark per word.
// ----------------------------------------------------------------------------
interface csvtok_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);

endinterface

/* rtl/csvtok_out_if.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer result channel
// Carries one cell byte, cell end or row end per word.
// ----------------------------------------------------------------------------
interface csvtok_out_if;

    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] cell_byte;
    logic       last_of_run;

    modport source (output valid, output event_kind, output cell_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input event_kind, input cell_byte, input last_of_run,
                  output ready);

endinterface

/* rtl/csvtok_parser.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer parser
// Input register, parse state and the single-pass grammar that turns one
// source word into a batch of up to three results.
// ----------------------------------------------------------------------------
`include "quoted_csv_row_tokenizer_top_defines.svh"

module csvtok_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_eoi,
    input  logic                can_load,
    output logic                commit,
    output csvtok_pkg::batch_t  batch
);
    import csvtok_pkg::*;

    typedef struct packed {
        logic in_quotes;
        logic quote_pending;
        logic cr_pending;
        logic row_open;
    } flags_t;

    typedef struct packed {
        flags_t     flags;
        logic       emit;
        logic [1:0] kind;
        logic [7:0] data;
    } step_t;

    function automatic step_t consume_byte(flags_t f, logic [7:0] b, logic [7:0] sep);
        step_t s;
        logic  handled;
        s       = '{flags: f, emit: 1'b0, kind: KIND_BYTE, data: b};
        handled = 1'b0;
        if (f.cr_pending)
        begin
            s.flags.cr_pending = 1'b0;
            if (b == CHAR_LF)
            begin
                handled = 1'b1;
            end
        end
        if (!handled && s.flags.in_quotes)
        begin
            if (s.flags.quote_pending)
            begin
                s.flags.quote_pending = 1'b0;
                if (b == CHAR_QUOTE)
                begin
                    s.emit  = 1'b1;
                    handled = 1'b1;
                end
                else
                begin
                    s.flags.in_quotes = 1'b0;
                end
            end
            else
            begin
                if (b == CHAR_QUOTE)
                begin
                    s.flags.quote_pending = 1'b1;
                end
                else
                begin
                    s.emit = 1'b1;
                end
                handled = 1'b1;
            end
        end
        if (!handled)
        begin
            if (b == CHAR_QUOTE)
            begin
                s.flags.in_quotes = 1'b1;
                s.flags.row_open  = 1'b1;
            end
            else if (b == sep)
            begin
                s.emit           = 1'b1;
                s.kind           = KIND_CELL_END;
                s.data           = 8'h00;
                s.flags.row_open = 1'b1;
            end
            else if (b == CHAR_CR || b == CHAR_LF)
            begin
                s.emit             = 1'b1;
                s.kind             = KIND_ROW_END;
                s.data             = 8'h00;
                s.flags.row_open   = 1'b0;
                s.flags.cr_pending = (b == CHAR_CR);
            end
            else
            begin
                s.emit           = 1'b1;
                s.flags.row_open = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic logic [7:0] mark_byte(logic [1:0] progress);
        logic [7:0] m;
        case (progress)
            2'd0:    m = MARK0;
            2'd1:    m = MARK1;
            default: m = MARK2;
        endcase
        return m;
    endfunction

    logic [7:0] sep_reg;
    logic       item_valid_reg;
    logic       item_valid_next;
    logic [7:0] item_byte_reg;
    logic       item_eoi_reg;
    logic [1:0] mark_reg;
    logic [1:0] mark_next;
    flags_t     flags_reg;
    flags_t     flags_next;

    step_t      st0;
    step_t      st1;
    step_t      st2;
    flags_t     f0;
    flags_t     f1;
    logic       replay;
    logic       use0;
    logic       use1;
    logic       use2;
    logic [MaxResults-1:0] slot_emit;
    result_t [MaxResults-1:0] slot;
    batch_t     packed_batch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= SEPARATOR_RESET;
        end
        else if (cfg_we)
        begin
            sep_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        replay = item_eoi_reg
                 || (mark_reg != MARK_DONE && item_byte_reg != mark_byte(mark_reg));
        use0   = replay && (mark_reg == 2'd1 || mark_reg == 2'd2);
        use1   = replay && (mark_reg == 2'd2);
        use2   = !item_eoi_reg && (mark_reg == MARK_DONE || replay);

        st0 = consume_byte(flags_reg, MARK0, sep_reg);
        f0  = use0 ? st0.flags : flags_reg;
        st1 = consume_byte(f0, MARK1, sep_reg);
        f1  = use1 ? st1.flags : f0;
        st2 = consume_byte(f1, item_byte_reg, sep_reg);

        slot_emit[0] = use0 && st0.emit;
        slot_emit[1] = use1 && st1.emit;
        slot[0]      = '{kind: st0.kind, data: st0.data, last: 1'b0};
        slot[1]      = '{kind: st1.kind, data: st1.data, last: 1'b0};
        if (item_eoi_reg)
        begin
            slot_emit[2] = f1.row_open;
            slot[2]      = '{kind: KIND_ROW_END, data: 8'h00, last: 1'b0};
        end
        else
        begin
            slot_emit[2] = use2 && st2.emit;
            slot[2]      = '{kind: st2.kind, data: st2.data, last: 1'b0};
        end

        if (item_eoi_reg)
        begin
            flags_next = '0;
            mark_next  = 2'd0;
        end
        else if (replay || mark_reg == MARK_DONE)
        begin
            flags_next = st2.flags;
            mark_next  = MARK_DONE;
        end
        else
        begin
            flags_next = flags_reg;
            mark_next  = mark_reg + 2'd1;
        end
    end

    always_comb
    begin
        packed_batch = '0;
        for (int k = 0; k < MaxResults; k++)
        begin
            if (slot_emit[k])
            begin
                packed_batch.entry[packed_batch.count] = slot[k];
                packed_batch.count                     = packed_batch.count + 2'd1;
            end
        end
        if (packed_batch.count != 2'd0)
        begin
            packed_batch.entry[packed_batch.count - 2'd1].last = 1'b1;
        end
    end

    assign batch    = packed_batch;
    assign commit   = item_valid_reg && (packed_batch.count == 2'd0 || can_load);
    assign in_ready = !item_valid_reg || commit;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (commit)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            mark_reg       <= 2'd0;
            flags_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (commit)
            begin
                mark_reg  <= mark_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_byte_reg <= in_byte;
            item_eoi_reg  <= in_eoi;
        end
    end

    `CSVTOK_ASSERT_NEXT(a_eoi_clears, clk, rst_n, commit && item_eoi_reg,
        mark_reg == 2'd0 && flags_reg == '0, "end of input did not clear the parse state")
    `CSVTOK_ASSERT_SAME(a_mark_clean, clk, rst_n, mark_reg != MARK_DONE,
        flags_reg == '0, "parse state changed during mark detection")
    `CSVTOK_ASSERT_SAME(a_quote_in_quotes, clk, rst_n, flags_reg.quote_pending,
        flags_reg.in_quotes, "pending quote outside quoted mode")
    `CSVTOK_ASSERT_SAME(a_cr_after_row, clk, rst_n, flags_reg.cr_pending,
        !flags_reg.in_quotes && !flags_reg.row_open, "pending CR inside an open row")

endmodule

/* rtl/csvtok_emitter.sv */
// ----------------------------------------------------------------------------
// CSV tokenizer result emitter
// Result register that holds one batch and sends it one word per cycle while the result port is ready.
// ----------------------------------------------------------------------------
`include "quoted_csv_row_tokenizer_top_defines.svh"

module csvtok_emitter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  csvtok_pkg::batch_t batch,
    output logic               can_load,
    csvtok_out_if.source       tokens
);
    import csvtok_pkg::*;

    result_t [MaxResults-1:0] queue_reg;
    logic [1:0]               count_reg;
    logic [1:0]               count_next;
    logic                     pop;
    logic                     load;

    assign pop      = (count_reg != 2'd0) && tokens.ready;
    assign can_load = (count_reg == 2'd0) || (count_reg == 2'd1 && tokens.ready);
    assign load     = commit && (batch.count != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (load)
        begin
            count_next = batch.count;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            queue_reg <= batch.entry;
        end
        else if (pop)
        begin
            queue_reg[0] <= queue_reg[1];
            queue_reg[1] <= queue_reg[2];
        end
    end

    assign tokens.valid       = (count_reg != 2'd0);
    assign tokens.event_kind  = queue_reg[0].kind;
    assign tokens.cell_byte   = queue_reg[0].data;
    assign tokens.last_of_run = queue_reg[0].last;

    `CSVTOK_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1,
        count_reg <= 2'(MaxResults), "result count beyond batch size")
    `CSVTOK_ASSERT_SAME(a_last_marked, clk, rst_n, count_reg == 2'd1,
        queue_reg[0].last, "final result of a batch lacks its last mark")
    `CSVTOK_ASSERT_SAME(a_load_empty, clk, rst_n, load,
        count_reg == 2'd0 || (count_reg == 2'd1 && pop), "batch loaded over pending results")

endmodule

/* rtl/quoted_csv_row_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// Quoted CSV row tokenizer
// Splits a comma or tab delimited byte stream into cell bytes, cell ends and
// row ends, with quoted cells and byte order mark removal.
// ----------------------------------------------------------------------------
// The block takes each source word into its input register and returns its
// results from the result register, one result word per cycle on the single
// result port while that port is ready. A word that causes one result or none
// keeps the rate at one word per cycle while the result port is ready; a word
// that causes two or three results, such as a replayed partial mark, can hold
// the source side while the result register drains. The separator is written
// through cfg_we and cfg_wdata and resets to a comma.
module quoted_csv_row_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    csvtok_in_if.sink   text,
    csvtok_out_if.source tokens
);
    import csvtok_pkg::*;

    batch_t batch;
    logic   commit;
    logic   can_load;

    csvtok_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (text.valid),
        .in_ready  (text.ready),
        .in_byte   (text.data_byte),
        .in_eoi    (text.end_of_input),
        .can_load  (can_load),
        .commit    (commit),
        .batch     (batch)
    );

    csvtok_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (commit),
        .batch    (batch),
        .can_load (can_load),
        .tokens   (tokens)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quoted CSV row tokenizer testbench
// Feeds directed and random delimited text through the tokenizer under random
// idling on both channels and checks every token word against a local model.
// ----------------------------------------------------------------------------
module tb_top;

    import csvtok_pkg::*;

    localparam int StallLimit = 2000;
    localparam int HoldCycles = 300;
    localparam int DrainCycles = 8;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    csvtok_in_if  text_ch();
    csvtok_out_if token_ch();

    quoted_csv_row_tokenizer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .text      (text_ch),
        .tokens    (token_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [7:0] sep_model = SEPARATOR_RESET;
    logic [1:0] mark_seen = 2'd0;
    logic       quoted = 1'b0;
    logic       quote_held = 1'b0;
    logic       cr_held = 1'b0;
    logic       row_live = 1'b0;

    result_t step_out[$];
    result_t tokens_due[$];
    result_t want;

    int errors = 0;
    int words_sent = 0;
    int send_run = 0;
    int take_run = 0;
    int stall_cycles = 0;
    bit hold_tokens = 1'b0;

    function automatic void put_token(logic [1:0] kind, logic [7:0] b);
        result_t r;
        r.kind = kind;
        r.data = (kind == KIND_BYTE) ? b : 8'h00;
        r.last = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        if (cr_held)
        begin
            cr_held = 1'b0;
            if (b == CHAR_LF)
                return;
        end
        if (quoted)
        begin
            if (quote_held)
            begin
                quote_held = 1'b0;
                if (b == CHAR_QUOTE)
                begin
                    put_token(KIND_BYTE, CHAR_QUOTE);
                    return;
                end
                quoted = 1'b0;
            end
            else
            begin
                if (b == CHAR_QUOTE)
                    quote_held = 1'b1;
                else
                    put_token(KIND_BYTE, b);
                return;
            end
        end
        if (b == CHAR_QUOTE)
        begin
            quoted = 1'b1;
            row_live = 1'b1;
        end
        else if (b == sep_model)
        begin
            put_token(KIND_CELL_END, 8'h00);
            row_live = 1'b1;
        end
        else if (b == CHAR_CR || b == CHAR_LF)
        begin
            put_token(KIND_ROW_END, 8'h00);
            row_live = 1'b0;
            cr_held = (b == CHAR_CR);
        end
        else
        begin
            put_token(KIND_BYTE, b);
            row_live = 1'b1;
        end
    endfunction

    function automatic void replay_mark();
        if (mark_seen == 2'd1 || mark_seen == 2'd2)
            parse_byte(MARK0);
        if (mark_seen == 2'd2)
            parse_byte(MARK1);
    endfunction

    function automatic void tokenize_word(logic [7:0] b, logic eoi);
        logic [7:0] mark_byte;
        step_out.delete();
        if (eoi)
        begin
            replay_mark();
            if (row_live)
                put_token(KIND_ROW_END, 8'h00);
            mark_seen = 2'd0;
            quoted = 1'b0;
            quote_held = 1'b0;
            cr_held = 1'b0;
            row_live = 1'b0;
        end
        else if (mark_seen != MARK_DONE)
        begin
            mark_byte = (mark_seen == 2'd0) ? MARK0 : (mark_seen == 2'd1) ? MARK1 : MARK2;
            if (b == mark_byte)
                mark_seen = mark_seen + 2'd1;
            else
            begin
                replay_mark();
                mark_seen = MARK_DONE;
                parse_byte(b);
            end
        end
        else
            parse_byte(b);
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            tokens_due.insert(tokens_due.size(), step_out[i]);
    endfunction

    function automatic int pick_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            run_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eoi);
        int gap;
        gap = pick_gap(send_run);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.data_byte <= b;
        text_ch.end_of_input <= eoi;
        do @(posedge clk); while (!text_ch.ready);
        tokenize_word(b, eoi);
        words_sent++;
    endtask

    task automatic send_eoi();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_word(s[i], 1'b0);
    endtask

    task automatic settle_tokens();
        text_ch.valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic set_separator(input logic [7:0] value);
        settle_tokens();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sep_model = value;
    endtask

    task automatic send_mark_start();
        case ($urandom_range(0, 3))
            0:
            begin
                send_word(MARK0, 1'b0);
                send_word(MARK1, 1'b0);
                send_word(MARK2, 1'b0);
            end
            1: send_word(MARK0, 1'b0);
            2:
            begin
                send_word(MARK0, 1'b0);
                send_word(MARK1, 1'b0);
            end
            default: ;
        endcase
    endtask

    function automatic logic [7:0] content_byte();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h61, 8'h7a));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_cell();
        int len;
        len = $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0)
        begin
            send_word(CHAR_QUOTE, 1'b0);
            repeat (len)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_word(CHAR_QUOTE, 1'b0);
                    send_word(CHAR_QUOTE, 1'b0);
                end
                else
                    send_word(content_byte(), 1'b0);
            end
            send_word(CHAR_QUOTE, 1'b0);
        end
        else
            repeat (len) send_word(content_byte(), 1'b0);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 5))
                0: send_eoi();
                1: send_word(CHAR_QUOTE, 1'b0);
                2: send_word($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, 1'b0);
                default: send_word(8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
    endtask

    task automatic send_records(input int budget);
        int stop_at;
        int cells;
        stop_at = words_sent + budget;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
            begin
                cells = $urandom_range(1, 4);
                for (int c = 0; c < cells; c++)
                begin
                    if (c > 0)
                        send_word(sep_model, 1'b0);
                    send_cell();
                end
                case ($urandom_range(0, 2))
                    0: send_word(CHAR_CR, 1'b0);
                    1: send_word(CHAR_LF, 1'b0);
                    default:
                    begin
                        send_word(CHAR_CR, 1'b0);
                        send_word(CHAR_LF, 1'b0);
                    end
                endcase
                if ($urandom_range(0, 5) == 0)
                begin
                    send_eoi();
                    send_mark_start();
                end
            end
        end
    endtask

    task automatic test_byte_order_mark();
        send_word(MARK0, 1'b0);
        send_word(MARK1, 1'b0);
        send_word(MARK2, 1'b0);
        send_text("a,");
        send_word(8'hFF, 1'b0);
        send_word(CHAR_CR, 1'b0);
        send_word(CHAR_LF, 1'b0);
        send_eoi();
        send_word(MARK0, 1'b0);
        send_word(MARK1, 1'b0);
        send_text("q");
        send_eoi();
        send_word(MARK0, 1'b0);
        send_word(MARK1, 1'b0);
        send_eoi();
        send_word(MARK0, 1'b0);
        send_eoi();
    endtask

    task automatic test_quoted_cells();
        send_word(CHAR_LF, 1'b0);
        send_text("\"a\"\",\",x\"");
        send_word(8'h00, 1'b0);
        send_eoi();
    endtask

    task automatic test_separator_settings();
        logic [7:0] settings[$];
        settings = '{8'h09, 8'h00, 8'hFF, CHAR_QUOTE, CHAR_CR, CHAR_LF, MARK0};
        foreach (settings[i])
        begin
            set_separator(settings[i]);
            send_records(10);
        end
        set_separator(8'h09);
        send_records(15);
    endtask

    task automatic test_result_backpressure();
        set_separator(SEPARATOR_RESET);
        hold_tokens = 1'b1;
        send_records(30);
    endtask

    initial
    begin
        int pause;
        token_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_tokens)
            begin
                token_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_tokens = 1'b0;
            end
            pause = pick_gap(take_run);
            if (pause > 0)
            begin
                token_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            token_ch.ready <= 1'b1;
            do @(posedge clk); while (!token_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && token_ch.valid && token_ch.ready)
        begin
            if (tokens_due.size() == 0)
            begin
                $error("unexpected token word: event_kind %0d cell_byte %02h last_of_run %0d",
                       token_ch.event_kind, token_ch.cell_byte, token_ch.last_of_run);
                errors++;
            end
            else
            begin
                want = tokens_due.pop_front();
                if (token_ch.event_kind !== want.kind)
                begin
                    $error("event_kind: expected %0d, actual %0d", want.kind,
                           token_ch.event_kind);
                    errors++;
                end
                if (token_ch.cell_byte !== want.data)
                begin
                    $error("cell_byte: expected %02h, actual %02h", want.data,
                           token_ch.cell_byte);
                    errors++;
                end
                if (token_ch.last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, actual %0d", want.last,
                           token_ch.last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (text_ch.valid && text_ch.ready)
            || (token_ch.valid && token_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= SEPARATOR_RESET;
        text_ch.valid <= 1'b0;
        text_ch.data_byte <= 8'h00;
        text_ch.end_of_input <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_byte_order_mark();
        test_quoted_cells();
        test_separator_settings();
        test_result_backpressure();

        settle_tokens();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
